// ===== hw/rtl/smst_pkg.sv =====
// ----------------------------------------------------------------------------
// smst_pkg
// Shared constants, types and state codes of the sampled member status tally.
// ----------------------------------------------------------------------------
package smst_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths.
    localparam int ID_W        = 31;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 16;
    localparam int STATUS_LVLS = 4;

    // Stream payload widths.
    localparam int IN_DATA_W   = 40;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = STATUS_LVLS * COUNT_W;
    localparam int OUT_USER_W  = 1;

    // Item kinds carried in the low tuser bit.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_NODE = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request from the control path to the table lookup.
    typedef struct packed {
        logic              start;
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  count;
    } t_lk_req;

    // Answer from the table lookup.
    typedef struct packed {
        logic done;
        logic found;
    } t_lk_rsp;

    // Lookup sequencer states.
    typedef enum logic [2:0] {
        LK_IDLE  = 3'b001,
        LK_PROBE = 3'b010,
        LK_MISS  = 3'b100
    } t_lk_state;

    // Top-level control states.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_HOLD   = 3'b100
    } t_state;

endpackage

// ===== hw/rtl/smst_ram.sv =====
// ----------------------------------------------------------------------------
// smst_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module smst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/smst_lookup.sv =====
// ----------------------------------------------------------------------------
// smst_lookup
// Binary search sequencer over the sampled id table, one memory probe a cycle.
// ----------------------------------------------------------------------------
module smst_lookup (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smst_pkg::t_lk_req            i_req,
    output smst_pkg::t_lk_rsp            o_rsp,
    output logic                         o_rd_en,
    output logic [smst_pkg::ADDR_W-1:0]  o_rd_addr,
    input  logic [smst_pkg::ID_W-1:0]    i_rd_data
);
    import smst_pkg::*;

    t_lk_state        r_state, n_state;
    logic [ID_W-1:0]  r_id;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [ADDR_W-1:0] r_mid, n_mid;

    logic [CNT_W:0]   start_sum;
    logic [CNT_W:0]   probe_sum;
    logic [CNT_W-1:0] mid_ext;
    logic             hit;
    logic             below;

    // Probe compare and the next search window.
    always_comb begin
        mid_ext   = CNT_W'(r_mid);
        hit       = (i_rd_data == r_id);
        below     = (i_rd_data < r_id);
        if (below) begin
            n_lo = mid_ext + CNT_W'(1);
            n_hi = r_hi;
        end else begin
            n_lo = r_lo;
            n_hi = mid_ext;
        end
        start_sum = (CNT_W + 1)'(i_req.count);
        probe_sum = (CNT_W + 1)'(n_lo) + (CNT_W + 1)'(n_hi);
    end

    // Sequencer: the next read address is issued in the cycle the last data arrives.
    always_comb begin
        n_state   = r_state;
        n_mid     = r_mid;
        o_rsp     = '0;
        o_rd_en   = 1'b0;
        o_rd_addr = start_sum[ADDR_W:1];
        unique case (r_state)
            LK_IDLE: begin
                if (i_req.start) begin
                    if (i_req.count == '0) begin
                        n_state = LK_MISS;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = start_sum[ADDR_W:1];
                        n_mid     = start_sum[ADDR_W:1];
                        n_state   = LK_PROBE;
                    end
                end
            end
            LK_PROBE: begin
                if (hit) begin
                    o_rsp.done  = 1'b1;
                    o_rsp.found = 1'b1;
                    n_state     = LK_IDLE;
                end else if (n_lo < n_hi) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = probe_sum[ADDR_W:1];
                    n_mid     = probe_sum[ADDR_W:1];
                end else begin
                    o_rsp.done = 1'b1;
                    n_state    = LK_IDLE;
                end
            end
            LK_MISS: begin
                o_rsp.done = 1'b1;
                n_state    = LK_IDLE;
            end
            default: begin
                n_state = LK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Search window and key.
    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
        if (r_state == LK_IDLE && i_req.start) begin
            r_id <= i_req.id;
            r_lo <= '0;
            r_hi <= i_req.count;
        end else if (r_state == LK_PROBE) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

endmodule

// ===== hw/rtl/sampled_member_status_tally_unit.sv =====
// ----------------------------------------------------------------------------
// sampled_member_status_tally_unit
// Sampled id table with binary-search lookup and per-tree status counters.
// ----------------------------------------------------------------------------
// A load request (tuser bit 0 low) writes its id into the table while it has
// room; tuser bit 1 restarts the table. A node request probes the table by
// binary search, one registered read per probe, and stops early when a probe
// hits; with an empty table no read is issued. The id table has a single read
// port, so the probes of one search follow each other. The counters are
// updated when the lookup finishes, or from the hold state once the output
// register is free. A result waits in an output register, so the next request
// is taken while it waits; only a further result stalls until the first one
// has been taken.
// ----------------------------------------------------------------------------
module sampled_member_status_tally_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // node_id [30:0], node_status [33:31], zero pad [39:34]
    input  logic [smst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // mode [0], first_item [1]
    input  logic [smst_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // last_item
    input  logic                             s_axis_tlast,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // count_status_one [15:0], count_status_two [31:16],
    // count_status_three [47:32], count_status_four [63:48]
    output logic [smst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // table_full [0]
    output logic [smst_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import smst_pkg::*;

    // Input fields.
    logic                in_mode;
    logic                in_first;
    logic [ID_W-1:0]     in_id;
    logic [STATUS_W-1:0] in_status;
    logic                in_accept;

    assign in_mode   = s_axis_tuser[0];
    assign in_first  = s_axis_tuser[1];
    assign in_id     = s_axis_tdata[ID_W-1:0];
    assign in_status = s_axis_tdata[ID_W+STATUS_W-1:ID_W];

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count;
    logic                r_overflow;
    logic                r_kept;
    logic [COUNT_W-1:0]  r_cnt [STATUS_LVLS];
    logic [COUNT_W-1:0]  n_cnt [STATUS_LVLS];
    logic [STATUS_W-1:0] r_status;
    logic                r_first;
    logic                r_last;
    logic                r_found;

    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                r_out_full;

    // Table memory ports.
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ID_W-1:0]     rd_data;

    t_lk_req             lk_req;
    t_lk_rsp             lk_rsp;

    // Tree update terms.
    logic                found_now;
    logic                kept_now;
    logic                emit;
    logic                out_busy;
    logic                apply;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Load writes go straight into the table in the accept cycle.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[ADDR_W-1:0];
        if (in_accept && in_mode == MODE_LOAD) begin
            if (in_first) begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end else if (r_count < CNT_W'(TABLE_DEPTH)) begin
                wr_en = 1'b1;
            end
        end
    end

    smst_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_id),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Node requests start a lookup over the ids loaded so far.
    always_comb begin
        lk_req.start = in_accept && (in_mode == MODE_NODE);
        lk_req.id    = in_id;
        lk_req.count = r_count;
    end

    smst_lookup u_lookup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (lk_req),
        .o_rsp     (lk_rsp),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // Counter update for the node whose lookup just finished (or is held).
    always_comb begin
        found_now = (r_state == ST_HOLD) ? r_found : lk_rsp.found;
        kept_now  = r_first ? found_now : r_kept;
        for (int k = 0; k < STATUS_LVLS; k++) begin
            n_cnt[k] = r_first ? '0 : r_cnt[k];
            if (kept_now && found_now && r_status == STATUS_W'(k + 1)
                    && n_cnt[k] != COUNT_MAX) begin
                n_cnt[k] = n_cnt[k] + COUNT_W'(1);
            end
        end
        emit     = kept_now && r_last;
        out_busy = r_out_valid && !m_axis_tready;
        apply    = ((r_state == ST_SEARCH && lk_rsp.done) || r_state == ST_HOLD)
                   && !(emit && out_busy);
    end

    // Control sequencing.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && in_mode == MODE_NODE) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (lk_rsp.done) begin
                    n_state = apply ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (apply) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, table fill and tree state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_kept     <= 1'b0;
            for (int k = 0; k < STATUS_LVLS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (in_accept && in_mode == MODE_LOAD) begin
                if (in_first) begin
                    r_count    <= CNT_W'(1);
                    r_overflow <= 1'b0;
                end else if (r_count < CNT_W'(TABLE_DEPTH)) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (apply) begin
                if (emit) begin
                    r_kept <= 1'b0;
                    for (int k = 0; k < STATUS_LVLS; k++) begin
                        r_cnt[k] <= '0;
                    end
                end else begin
                    r_kept <= kept_now;
                    for (int k = 0; k < STATUS_LVLS; k++) begin
                        r_cnt[k] <= n_cnt[k];
                    end
                end
            end
        end
    end

    // Node fields held for the duration of the search.
    always_ff @(posedge i_clk) begin
        if (in_accept && in_mode == MODE_NODE) begin
            r_status <= in_status;
            r_first  <= in_first;
            r_last   <= s_axis_tlast;
        end
        if (r_state == ST_SEARCH && lk_rsp.done) begin
            r_found <= lk_rsp.found;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (apply && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply && emit) begin
            for (int k = 0; k < STATUS_LVLS; k++) begin
                r_out_data[k*COUNT_W +: COUNT_W] <= n_cnt[k];
            end
            r_out_full <= r_overflow;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_full;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sampled member status tally unit.
// ----------------------------------------------------------------------------
// Requests are queued by one initial block and played onto the input stream by
// a clocked driver with random gaps. The driver feeds every accepted request
// to a cycle-free model of the id table and the tree counters, which queues
// the expected tallies. A clocked monitor with random back-pressure takes the
// results and compares them field by field with the oldest expected tally.
// The stimulus covers a directed opening and a random mix of table reloads
// and trees. It ends with a stretch that has no idling on either side.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import smst_pkg::*;

    // Status levels that the counters know about.
    localparam logic [STATUS_W-1:0] STATUS_NONE = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ONE  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FOUR = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_TOP  = 3'd7;

    localparam logic [ID_W-1:0] ID_MAX     = '1;
    localparam int              RAND_ITEMS = 1120;
    localparam int              CALM_ITEMS = 150;
    localparam int              PRINT_CAP  = 40;

    // One queued request, or a marker that holds the sender until all
    // expected tallies have come back.
    typedef struct {
        logic                mode;
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
        logic                first;
        logic                last;
        bit                  calm;
        bit                  drain;
    } node_req_t;

    typedef struct packed {
        logic                                full;
        logic [STATUS_LVLS-1:0][COUNT_W-1:0] counts;
    } tally_result_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // node_id [30:0], node_status [33:31], zero pad [39:34]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // mode [0], first_item [1]
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    // last_item
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // count_status_one [15:0], count_status_two [31:16],
    // count_status_three [47:32], count_status_four [63:48]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // table_full [0]
    logic [OUT_USER_W-1:0] m_axis_tuser;

    sampled_member_status_tally_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Request and tally queues, and the run counters.
    node_req_t     pending_reqs[$];
    node_req_t     on_bus;
    tally_result_t tally_expected[$];
    int            accepted_reqs = 0;
    int            tallies_seen  = 0;
    int            mismatches    = 0;
    int            reload_count  = 0;
    int            send_gap      = 0;
    int            stall_left    = 0;
    bit            quiet_tail    = 1'b0;

    // Model state: the id table, the tree flag and the status counters.
    logic [ID_W-1:0]    tbl_ids[TABLE_DEPTH];
    int                 tbl_fill     = 0;
    bit                 tbl_overflow = 1'b0;
    bit                 tree_live    = 1'b0;
    logic [COUNT_W-1:0] tally_cnt[STATUS_LVLS];

    // Generator-side view of the table, used to pick ids that hit it or lie next to its ids.
    logic [ID_W-1:0] gen_ids[$];
    bit              calm_now = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Binary search over the loaded part of the table.
    function automatic bit table_has(input logic [ID_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_fill;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_ids[mid] == key) return 1'b1;
            if (tbl_ids[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        return 1'b0;
    endfunction

    // Apply one accepted request to the model and queue any tally it gives.
    task automatic tally_apply(input node_req_t r);
        tally_result_t res;
        bit            hit;
        int            k;
        if (r.mode == MODE_LOAD) begin
            if (r.first) begin
                tbl_fill     = 0;
                tbl_overflow = 1'b0;
            end
            if (tbl_fill < TABLE_DEPTH) begin
                tbl_ids[tbl_fill] = r.id;
                tbl_fill++;
            end else begin
                tbl_overflow = 1'b1;
            end
            return;
        end
        hit = table_has(r.id);
        // A root starts a fresh tree whether or not the previous one ended.
        if (r.first) begin
            for (k = 0; k < STATUS_LVLS; k++) tally_cnt[k] = '0;
            tree_live = hit;
        end
        if (!tree_live) return;
        if (hit && r.status >= STATUS_ONE && r.status <= STATUS_FOUR &&
            tally_cnt[r.status - 1] != COUNT_MAX) begin
            tally_cnt[r.status - 1]++;
        end
        if (!r.last) return;
        for (k = 0; k < STATUS_LVLS; k++) res.counts[k] = tally_cnt[k];
        res.full = tbl_overflow;
        tally_expected.push_back(res);
        for (k = 0; k < STATUS_LVLS; k++) tally_cnt[k] = '0;
        tree_live = 1'b0;
    endtask

    // Queue a request and keep the generator's table view in step.
    task automatic add_req(input logic mode, input logic [ID_W-1:0] id,
                           input logic [STATUS_W-1:0] st, input logic first,
                           input logic last);
        node_req_t r;
        r.mode   = mode;
        r.id     = id;
        r.status = st;
        r.first  = first;
        r.last   = last;
        r.calm   = calm_now;
        r.drain  = 1'b0;
        pending_reqs.push_back(r);
        if (mode == MODE_LOAD) begin
            if (first) gen_ids.delete();
            if (gen_ids.size() < TABLE_DEPTH) gen_ids.push_back(id);
        end
    endtask

    task automatic add_drain();
        node_req_t r;
        r       = '{default: '0};
        r.calm  = calm_now;
        r.drain = 1'b1;
        pending_reqs.push_back(r);
    endtask

    // Mostly valid levels, now and then one that no counter takes.
    function automatic logic [STATUS_W-1:0] pick_status();
        if ($urandom_range(0, 9) != 0)
            return STATUS_W'($urandom_range(STATUS_ONE, STATUS_FOUR));
        if ($urandom_range(0, 1) == 0) return STATUS_NONE;
        return STATUS_W'($urandom_range(STATUS_FOUR + 1, STATUS_TOP));
    endfunction

    // An id from the table, or one that most likely misses it.
    function automatic logic [ID_W-1:0] pick_id(input bit hit);
        logic [ID_W-1:0] base;
        if (hit && gen_ids.size() != 0)
            return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
        case ($urandom_range(0, 3))
            0: begin
                if (gen_ids.size() == 0) return ID_W'($urandom());
                base = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
                return $urandom_range(0, 1) ? base + 1'b1 : base - 1'b1;
            end
            1: return ID_W'($urandom_range(0, 64));
            default: return ID_W'($urandom());
        endcase
    endfunction

    // Restart the table with a short run of ids, usually sorted.
    task automatic gen_reload(output int n);
        logic [ID_W-1:0] ids[$];
        int              k;
        n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
        for (k = 0; k < n; k++) begin
            ids.push_back($urandom_range(0, 3) == 0 ? ID_W'($urandom_range(0, 200))
                                                    : ID_W'($urandom()));
        end
        if ($urandom_range(0, 4) != 0) ids.sort();
        for (k = 0; k < n; k++)
            add_req(MODE_LOAD, ids[k], pick_status(), k == 0, 1'($urandom()));
        reload_count++;
    endtask

    // One tree with random content; returns how many requests it queued.
    task automatic gen_tree(output int n);
        int  len;
        int  k;
        bit  root_hit;
        bit  cut_short;
        len       = $urandom_range(1, 8);
        root_hit  = $urandom_range(0, 4) != 0;
        cut_short = $urandom_range(0, 19) == 0;
        n         = 0;
        for (k = 0; k < len; k++) begin
            // A load slipped into the middle of a tree.
            if (k != 0 && $urandom_range(0, 19) == 0) begin
                add_req(MODE_LOAD, pick_id(1'b0), pick_status(),
                        $urandom_range(0, 5) == 0, 1'($urandom()));
                n++;
            end
            add_req(MODE_NODE, pick_id(k == 0 ? root_hit : $urandom_range(0, 9) < 7),
                    pick_status(), k == 0, k == len - 1 && !cut_short);
            n++;
        end
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        logic launch;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            launch = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                tally_apply(on_bus);
                accepted_reqs++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() != 0) begin
                    if (pending_reqs[0].drain) begin
                        if (tally_expected.size() == 0) void'(pending_reqs.pop_front());
                    end else if (!pending_reqs[0].calm && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(0, 5);
                    end else begin
                        on_bus = pending_reqs.pop_front();
                        launch = 1'b1;
                    end
                end
                s_axis_tvalid <= launch;
                if (launch) begin
                    s_axis_tdata <= {{(IN_DATA_W - ID_W - STATUS_W){1'b0}},
                                     on_bus.status, on_bus.id};
                    s_axis_tuser <= {on_bus.first, on_bus.mode};
                    s_axis_tlast <= on_bus.last;
                    quiet_tail   <= on_bus.calm;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        tally_result_t want;
        logic          rdy;
        int            k;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                tallies_seen++;
                if (tally_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= PRINT_CAP)
                        $display("%0t: unexpected tally: expected none, actual %h/%b",
                                 $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = tally_expected.pop_front();
                    for (k = 0; k < STATUS_LVLS; k++) begin
                        if (m_axis_tdata[k*COUNT_W +: COUNT_W] !== want.counts[k]) begin
                            mismatches++;
                            if (mismatches <= PRINT_CAP)
                                $display("%0t: status %0d count: expected %0d, actual %0d",
                                         $time, k + 1, want.counts[k],
                                         m_axis_tdata[k*COUNT_W +: COUNT_W]);
                        end
                    end
                    if (m_axis_tuser[0] !== want.full) begin
                        mismatches++;
                        if (mismatches <= PRINT_CAP)
                            $display("%0t: table_full: expected %b, actual %b",
                                     $time, want.full, m_axis_tuser[0]);
                    end
                end
            end
            rdy = 1'b1;
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                rdy        = 1'b0;
            end
            m_axis_tready <= rdy;
        end
    end

    // Stimulus and end of run.
    initial begin
        int k;
        int n;
        int rand_items;

        for (k = 0; k < STATUS_LVLS; k++) tally_cnt[k] = '0;

        // Directed opening: empty table, extremes of the id, every status,
        // dropped trees, a restarted tree and loads in the middle of a tree.
        add_req(MODE_NODE, '0, STATUS_ONE, 1'b1, 1'b1);
        add_req(MODE_NODE, 31'd5, STATUS_ONE, 1'b0, 1'b1);
        add_req(MODE_LOAD, '0, STATUS_NONE, 1'b1, 1'b0);
        add_req(MODE_LOAD, 31'd5, STATUS_TOP, 1'b0, 1'b1);
        add_req(MODE_LOAD, 31'd1000, STATUS_NONE, 1'b0, 1'b0);
        add_req(MODE_LOAD, ID_MAX, STATUS_NONE, 1'b0, 1'b0);
        add_req(MODE_NODE, '0, STATUS_ONE, 1'b1, 1'b1);
        add_req(MODE_NODE, ID_MAX, STATUS_FOUR, 1'b1, 1'b0);
        add_req(MODE_NODE, 31'd5, 3'd2, 1'b0, 1'b0);
        add_req(MODE_NODE, 31'd6, STATUS_SAT, 1'b0, 1'b0);
        add_req(MODE_NODE, 31'd1000, STATUS_NONE, 1'b0, 1'b0);
        add_req(MODE_NODE, 31'd5, STATUS_TOP, 1'b0, 1'b0);
        add_req(MODE_NODE, 31'd5, 3'd5, 1'b0, 1'b0);
        add_req(MODE_LOAD, 31'd2000, STATUS_NONE, 1'b0, 1'b0);
        add_req(MODE_NODE, 31'd2000, STATUS_SAT, 1'b0, 1'b1);
        add_req(MODE_NODE, 31'd7, STATUS_ONE, 1'b1, 1'b0);
        add_req(MODE_NODE, 31'd5, STATUS_ONE, 1'b0, 1'b0);
        add_req(MODE_NODE, '0, STATUS_ONE, 1'b0, 1'b1);
        add_req(MODE_NODE, 31'd1000, STATUS_ONE, 1'b1, 1'b0);
        add_req(MODE_NODE, 31'd5, 3'd2, 1'b1, 1'b0);
        add_req(MODE_NODE, '0, 3'd6, 1'b0, 1'b0);
        add_req(MODE_NODE, '0, STATUS_FOUR, 1'b0, 1'b1);
        add_drain();
        // Unsorted table: the lookup still decides the same way every time.
        add_req(MODE_LOAD, 31'd900, STATUS_NONE, 1'b1, 1'b0);
        add_req(MODE_LOAD, 31'd10, STATUS_NONE, 1'b0, 1'b0);
        add_req(MODE_LOAD, 31'd50000, STATUS_NONE, 1'b0, 1'b0);
        add_req(MODE_NODE, 31'd10, 3'd2, 1'b1, 1'b1);
        add_req(MODE_NODE, 31'd900, 3'd2, 1'b1, 1'b1);
        add_req(MODE_NODE, 31'd50000, STATUS_FOUR, 1'b1, 1'b1);
        add_drain();

        // Random mix of reloads and trees, ending in a stretch with no idling.
        rand_items = 0;
        gen_reload(n);
        rand_items += n;
        while (rand_items < RAND_ITEMS) begin
            calm_now = rand_items >= RAND_ITEMS - CALM_ITEMS;
            if ($urandom_range(0, 11) == 0) begin
                gen_reload(n);
            end else if ($urandom_range(0, 19) == 0) begin
                // A stray node with no root before it.
                add_req(MODE_NODE, pick_id(1'($urandom())), pick_status(), 1'b0,
                        1'($urandom()));
                n = 1;
            end else begin
                gen_tree(n);
            end
            rand_items += n;
            if (!calm_now && $urandom_range(0, 59) == 0) add_drain();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        k = 0;
        while (tally_expected.size() != 0 && k < 20000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (40) @(posedge i_clk);
        if (tally_expected.size() != 0) begin
            mismatches += tally_expected.size();
            $display("%0t: %0d expected tallies never arrived", $time, tally_expected.size());
        end

        $display("Run covered %0d requests and %0d tallies, %0d table reloads,",
                 accepted_reqs, tallies_seen, reload_count);
        $display("dropped and restarted trees, stray nodes and unsorted tables.");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hang guard.
    initial begin
        #12_000_000;
        $display("%0t: run timed out", $time);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/smst_pkg.sv
hw/rtl/smst_ram.sv
hw/rtl/smst_lookup.sv
hw/rtl/sampled_member_status_tally_unit.sv
dv/testbench.sv
